[hdl/swd_pkg.sv]
// Package for the shell word splitter: event codes, item types, byte constants.
// Used by swd_front, swd_queue, swd_back and shell_word_splitter; no dependencies.
package swd_pkg;

	// Default number of word slots per line (at most WORD_SLOTS-1 words are taken).
	localparam int WORD_SLOTS_DEF = 128;

	// Depth of the command queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Most result events caused by one input item.
	localparam int MAX_EVENTS = 3;

	// Special bytes of the command line.
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	// Kinds of result event.
	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_WORD_END = 2'd1,
		KIND_LINE_END = 2'd2
	} kind_t;

	// One result event.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic [6:0] word;
	} event_t;

	// The events caused by one input item, as handed from front to back.
	typedef struct packed {
		logic [1:0]                  count;
		event_t [MAX_EVENTS-1:0]     ev;
	} cmd_t;

	function automatic event_t mk_event(kind_t k, logic [7:0] v, logic [6:0] w);
		event_t e;
		e.kind  = k;
		e.value = v;
		e.word  = w;
		return e;
	endfunction

	function automatic logic is_blank(logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB);
	endfunction

endpackage

[hdl/swd_front.sv]
// Front part of the shell word splitter: accepts bytes, tracks quoting state
// and turns each item into a command of up to three events. Uses swd_pkg.
module swd_front #(
	parameter int WORD_SLOTS = swd_pkg::WORD_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    line_byte,
	input  logic          line_end,
	input  logic          q_full,
	output logic          push,
	output swd_pkg::cmd_t push_cmd
);
	import swd_pkg::*;

	localparam logic [6:0] LIMIT = 7'(WORD_SLOTS - 1);

	logic       inside_q, squote_q, dquote_q, esc_plain_q, esc_dq_q, limit_q;
	logic [6:0] words_q;

	logic       inside_n, squote_n, dquote_n, esc_plain_n, esc_dq_n, limit_n;
	logic [6:0] words_n;
	cmd_t       cmd;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (cmd.count != 2'd0);
	assign push_cmd = cmd;

	// Classify one item against the current quoting state.
	always_comb begin
		logic [1:0] cnt;
		logic [6:0] wn;
		logic       go;
		inside_n    = inside_q;
		squote_n    = squote_q;
		dquote_n    = dquote_q;
		esc_plain_n = esc_plain_q;
		esc_dq_n    = esc_dq_q;
		limit_n     = limit_q;
		words_n     = words_q;
		cmd         = '0;
		cnt         = 2'd0;
		wn          = words_q - 7'd1;
		go          = 1'b0;
		if (line_end) begin
			if (inside_q) begin
				if (esc_dq_q) begin
					cmd.ev[cnt] = mk_event(KIND_BYTE, CH_BSLASH, wn);
					cnt = cnt + 2'd1;
				end
				cmd.ev[cnt] = mk_event(KIND_WORD_END, 8'd0, wn);
				cnt = cnt + 2'd1;
			end
			cmd.ev[cnt] = mk_event(KIND_LINE_END, {1'b0, words_q}, 7'd0);
			cnt = cnt + 2'd1;
			inside_n    = 1'b0;
			squote_n    = 1'b0;
			dquote_n    = 1'b0;
			esc_plain_n = 1'b0;
			esc_dq_n    = 1'b0;
			limit_n     = 1'b0;
			words_n     = 7'd0;
		end else if (!limit_q) begin
			if (inside_q) begin
				go = 1'b1;
			end else if (!is_blank(line_byte)) begin
				if (words_q >= LIMIT) begin
					limit_n = 1'b1;
				end else begin
					words_n     = words_q + 7'd1;
					wn          = words_q;
					inside_n    = 1'b1;
					squote_n    = 1'b0;
					dquote_n    = 1'b0;
					esc_plain_n = 1'b0;
					esc_dq_n    = 1'b0;
					go          = 1'b1;
				end
			end
		end
		// Handle a byte that belongs to an open word.
		if (go) begin
			if (esc_plain_n) begin
				esc_plain_n = 1'b0;
				cmd.ev[cnt] = mk_event(KIND_BYTE, line_byte, wn);
				cnt = cnt + 2'd1;
			end else if (esc_dq_n) begin
				esc_dq_n = 1'b0;
				if (line_byte != CH_DQUOTE && line_byte != CH_BSLASH) begin
					cmd.ev[cnt] = mk_event(KIND_BYTE, CH_BSLASH, wn);
					cnt = cnt + 2'd1;
				end
				cmd.ev[cnt] = mk_event(KIND_BYTE, line_byte, wn);
				cnt = cnt + 2'd1;
			end else if (dquote_n && line_byte == CH_BSLASH) begin
				esc_dq_n = 1'b1;
			end else if (!squote_n && !dquote_n && line_byte == CH_BSLASH) begin
				esc_plain_n = 1'b1;
			end else if (line_byte == CH_SQUOTE && !dquote_n) begin
				squote_n = !squote_n;
			end else if (line_byte == CH_DQUOTE && !squote_n) begin
				dquote_n = !dquote_n;
			end else if (!squote_n && !dquote_n && is_blank(line_byte)) begin
				inside_n    = 1'b0;
				cmd.ev[cnt] = mk_event(KIND_WORD_END, 8'd0, wn);
				cnt = cnt + 2'd1;
			end else begin
				cmd.ev[cnt] = mk_event(KIND_BYTE, line_byte, wn);
				cnt = cnt + 2'd1;
			end
		end
		cmd.count = cnt;
	end

	// Quoting state, updated on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q    <= 1'b0;
			squote_q    <= 1'b0;
			dquote_q    <= 1'b0;
			esc_plain_q <= 1'b0;
			esc_dq_q    <= 1'b0;
			limit_q     <= 1'b0;
			words_q     <= 7'd0;
		end else if (accept) begin
			inside_q    <= inside_n;
			squote_q    <= squote_n;
			dquote_q    <= dquote_n;
			esc_plain_q <= esc_plain_n;
			esc_dq_q    <= esc_dq_n;
			limit_q     <= limit_n;
			words_q     <= words_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_limit_count: assert property (@(posedge clk) disable iff (!arst_n)
		limit_q |-> (words_q == LIMIT))
		else $error("limit flag set below the word limit");
	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && line_end) |=> (words_q == 7'd0 && !inside_q && !limit_q))
		else $error("state not cleared after a line end");
	a_limit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(limit_q && !inside_q && accept && !line_end) |-> !push)
		else $error("events produced past the word limit");
`endif

endmodule

[hdl/swd_queue.sv]
// Short command queue between the front and back parts of the word splitter.
// Flip-flop storage with one write and one read pointer. Uses swd_pkg.
module swd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swd_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output swd_pkg::cmd_t head_cmd
);
	import swd_pkg::*;

	cmd_t              store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = store_q[rd_ptr_q];

	// Entry storage; no reset needed for payload.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command written into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command taken from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count out of range");
`endif

endmodule

[hdl/swd_back.sv]
// Back part of the shell word splitter: expands each queued command into its
// events, one per cycle while the receiver is ready, into an output register. Uses swd_pkg.
module swd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  swd_pkg::cmd_t head_cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    event_kind,
	output logic [7:0]    event_value,
	output logic [6:0]    word_number,
	output logic          run_last
);
	import swd_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	event_t     ev_q;
	logic       last_q;
	logic       load;
	logic       last;
	event_t     sel;

	assign load = head_valid && (!valid_q || out_ready);
	assign last = (idx_q == head_cmd.count - 2'd1);
	assign sel  = head_cmd.ev[idx_q];
	assign pop  = load && last;

	// Event index within the head command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			ev_q   <= sel;
			last_q <= last;
		end
	end

	assign out_valid   = valid_q;
	assign event_kind  = ev_q.kind;
	assign event_value = ev_q.value;
	assign word_number = ev_q.word;
	assign run_last    = last_q;

`ifndef NO_ASSERTIONS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q < head_cmd.count))
		else $error("event index past the command's event count");
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (idx_q == 2'd0))
		else $error("event index not at the start while the queue is empty");
	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && ev_q.kind == KIND_LINE_END) |-> last_q)
		else $error("line end event not marked as the last of its item");
`endif

endmodule

[hdl/shell_word_splitter.sv]
// Top level of the shell word splitter: front part, command queue, back part.
// Depends on swd_pkg, swd_front, swd_queue and swd_back.
//
// Usage: command-line bytes enter on the input channel (in_valid/in_ready with
// line_byte and line_end), one item per byte, and an item with line_end set
// closes the line. Result events leave on the output channel
// (out_valid/out_ready) as word bytes, word ends and a line end carrying the
// word count; run_last marks the final event caused by each input item.
// The front part accepts one item per cycle while the queue is not full and pushes
// its events as a single command into a four-entry queue; the back part drains
// one event per cycle while the receiver is ready. The first event of an item
// is written into the queue and then taken from it into the output register.
// Throughput is one item per cycle while items cause at most one event each
// and the receiver is ready; an item causing k events fills k output slots in
// turn, so the sustained rate is set by the back part's one-event-per-cycle
// output register. When the receiver stalls, the output register holds its
// event, the queue fills, and in_ready falls once all four entries are occupied.
// Reset clears the quoting state, the word count, the queue and the output valid flag.
module shell_word_splitter #(
	parameter int WORD_SLOTS = swd_pkg::WORD_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] line_byte,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_kind,
	output logic [7:0] event_value,
	output logic [6:0] word_number,
	output logic       run_last
);
	import swd_pkg::*;

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	// Front part: classification and quoting state.
	swd_front #(
		.WORD_SLOTS(WORD_SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.line_byte(line_byte),
		.line_end (line_end),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Queue between the two parts.
	swd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	// Back part: event expansion and output register.
	swd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.event_value(event_value),
		.word_number(word_number),
		.run_last   (run_last)
	);

endmodule
